// ----- rtl/core/xed_pkg.sv -----
// ----------------------------------------------------------------------------
// xed_pkg
// Shared types, character codes and helper functions for the XML entity
// decoder.
// ----------------------------------------------------------------------------
package xed_pkg;

	// character codes
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;

	// named entities
	localparam int unsigned NUM_NAMES = 5;
	localparam logic [2:0] NM_LT   = 3'd0;
	localparam logic [2:0] NM_GT   = 3'd1;
	localparam logic [2:0] NM_AMP  = 3'd2;
	localparam logic [2:0] NM_QUOT = 3'd3;
	localparam logic [2:0] NM_APOS = 3'd4;

	// UTF-8 limits and marks
	localparam logic [31:0] UTF_LIM1 = 32'h0000_0080;
	localparam logic [31:0] UTF_LIM2 = 32'h0000_0800;
	localparam logic [31:0] UTF_LIM3 = 32'h0001_0000;
	localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF_LEAD4 = 8'hF0;
	localparam logic [7:0]  UTF_CONT  = 8'h80;
	localparam logic [5:0]  UTF_MASK  = 6'h3F;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic feed;
		logic rejct;
		logic emit;
		logic flush;
	} xed_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic q_empty;
		logic wc_zero;
		logic can_emit;
		logic decode_ok;
		logic emit_last;
		logic hold_valid;
		logic seg;
	} xed_sts_t;

	// name text, character 0 in the top byte
	function automatic logic [31:0] name_word(input logic [2:0] nm);
		logic [31:0] w;
		unique case (nm)
			NM_LT:   w = {8'h6C, 8'h74, 8'h00, 8'h00};
			NM_GT:   w = {8'h67, 8'h74, 8'h00, 8'h00};
			NM_AMP:  w = {8'h61, 8'h6D, 8'h70, 8'h00};
			NM_QUOT: w = {8'h71, 8'h75, 8'h6F, 8'h74};
			NM_APOS: w = {8'h61, 8'h70, 8'h6F, 8'h73};
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [2:0] name_len(input logic [2:0] nm);
		logic [2:0] n;
		unique case (nm)
			NM_LT, NM_GT: n = 3'd2;
			NM_AMP:       n = 3'd3;
			NM_QUOT, NM_APOS: n = 3'd4;
			default:      n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] entity_char(input logic [2:0] nm);
		logic [7:0] c;
		unique case (nm)
			NM_LT:   c = CH_LT;
			NM_GT:   c = CH_GT;
			NM_AMP:  c = CH_AMP;
			NM_QUOT: c = CH_QUOT;
			NM_APOS: c = CH_APOS;
			default: c = '0;
		endcase
		return c;
	endfunction

	// digit test: bit 4 is valid, bits 3:0 the value
	function automatic logic [4:0] digit_val(input logic [7:0] c, input logic hex);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, c[3:0]};
		else if (hex && c >= 8'h61 && c <= 8'h66)
			r = {1'b1, c[3:0] + 4'd9};
		else if (hex && c >= 8'h41 && c <= 8'h46)
			r = {1'b1, c[3:0] + 4'd9};
		return r;
	endfunction

endpackage

// ----- rtl/core/xed_ctrl.sv -----
// ----------------------------------------------------------------------------
// xed_ctrl
// Controller: takes a request, steps the replay buffer one byte a cycle while
// results can be emitted, sequences UTF-8 bytes and closes each run.
// ----------------------------------------------------------------------------
module xed_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             text_valid,
	output logic             text_stall,
	input  xed_pkg::xed_sts_t sts,
	output xed_pkg::xed_cmd_t cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_FEED  = 2'd1;
	localparam logic [1:0] S_EMIT  = 2'd2;
	localparam logic [1:0] S_FLUSH = 2'd3;

	logic [1:0] state_q, state_d;

	assign text_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (text_valid) begin
					cmd.load = 1'b1;
					state_d  = S_FEED;
				end
			end
			S_FEED: begin
				if (sts.can_emit) begin
					if (!sts.q_empty) begin
						cmd.feed = 1'b1;
						if (sts.decode_ok)
							state_d = S_EMIT;
					end else if (sts.seg && !sts.wc_zero) begin
						cmd.rejct = 1'b1;
					end else if (sts.hold_valid) begin
						state_d = S_FLUSH;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_EMIT: begin
				if (sts.can_emit) begin
					cmd.emit = 1'b1;
					if (sts.emit_last)
						state_d = S_FEED;
				end
			end
			S_FLUSH: begin
				if (sts.can_emit) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ----- rtl/core/xed_dp.sv -----
// ----------------------------------------------------------------------------
// xed_dp
// Datapath: circular replay buffer holding candidate window and pending
// bytes, incremental entity parser, UTF-8 encoder, hold and output registers.
// ----------------------------------------------------------------------------
module xed_dp #(
	parameter int unsigned ENTITY_REACH = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        text_byte,
	input  logic              segment_end,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [7:0]        out_byte,
	output logic              out_segment_end,
	output logic              run_end,
	input  xed_pkg::xed_cmd_t  cmd,
	output xed_pkg::xed_sts_t  sts
);

	localparam int unsigned W  = ENTITY_REACH + 1;
	localparam int unsigned PW = $clog2(W);
	localparam int unsigned CW = $clog2(W + 1);
	localparam logic [CW:0] W_EXT = (CW + 1)'(W);

	// buffer: window at head, queued bytes after it
	logic [7:0]    buf_q [W];
	logic [PW-1:0] head_q;
	logic [CW-1:0] len_q, wc_q;
	logic          seg_q;

	// parser state
	logic [xed_pkg::NUM_NAMES-1:0] alive_q;
	logic        hash_q, hex_q, runa_q, runb_q, pfx0_q, pfx_q, skip_q;
	logic [31:0] acca_q, accb_q;

	// encoder state
	logic [31:0] cp_q;
	logic [2:0]  n_q, rem_q;

	// hold and output
	logic       hold_valid_q;
	logic [7:0] hold_q;
	logic       res_valid_q, res_seg_q, res_end_q;
	logic [7:0] res_byte_q;

	function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] h,
		input logic [CW-1:0] k);
		logic [CW:0] s;
		s = (CW + 1)'(h) + (CW + 1)'(k);
		if (s >= W_EXT)
			s = s - W_EXT;
		return s[PW-1:0];
	endfunction

	// current byte and its index in the entity name
	logic [PW-1:0] rd_idx, wr_idx;
	logic [7:0]    c;
	logic [CW-1:0] ei;
	assign rd_idx = wrap_add(head_q, wc_q);
	assign wr_idx = wrap_add(head_q, len_q);
	assign c      = buf_q[rd_idx];
	assign ei     = wc_q - CW'(1);

	// decode test on the state before the semicolon
	logic [31:0] num_val;
	logic        name_hit, num_hit, is_semi, full_next;
	logic [7:0]  name_chr;
	always_comb begin
		name_hit = 1'b0;
		name_chr = '0;
		for (int k = 0; k < xed_pkg::NUM_NAMES; k++) begin
			if (alive_q[k] && ei == CW'(xed_pkg::name_len(3'(k)))) begin
				name_hit = 1'b1;
				name_chr = xed_pkg::entity_char(3'(k));
			end
		end
	end
	assign num_val   = (hex_q && skip_q) ? accb_q : acca_q;
	assign num_hit   = hash_q && (num_val != '0);
	assign is_semi   = (c == xed_pkg::CH_SEMI);
	assign full_next = ((wc_q + CW'(1)) == CW'(W));

	logic feed_win;
	assign feed_win = cmd.feed && (wc_q != '0);

	// status
	logic slot_free;
	assign slot_free      = !res_valid_q || !res_stall;
	assign sts.q_empty    = (len_q == wc_q);
	assign sts.wc_zero    = (wc_q == '0);
	assign sts.can_emit   = !hold_valid_q || slot_free;
	assign sts.decode_ok  = (wc_q != '0) && is_semi && (name_hit || num_hit);
	assign sts.emit_last  = (rem_q == 3'd1);
	assign sts.hold_valid = hold_valid_q;
	assign sts.seg        = seg_q;

	// UTF-8 byte for the current position
	logic [31:0] sh;
	logic [7:0]  lead, utf_byte;
	always_comb begin
		case (rem_q)
			3'd4:    sh = cp_q >> 18;
			3'd3:    sh = cp_q >> 12;
			3'd2:    sh = cp_q >> 6;
			default: sh = cp_q;
		endcase
		case (n_q)
			3'd4:    lead = xed_pkg::UTF_LEAD4;
			3'd3:    lead = xed_pkg::UTF_LEAD3;
			3'd2:    lead = xed_pkg::UTF_LEAD2;
			default: lead = '0;
		endcase
		if (rem_q == n_q)
			utf_byte = lead | sh[7:0];
		else
			utf_byte = xed_pkg::UTF_CONT | {2'b00, sh[5:0] & xed_pkg::UTF_MASK};
	end

	// what this cycle emits, and how the buffer moves
	logic          emit_en;
	logic [7:0]    emit_byte;
	logic [CW-1:0] drop;
	logic          wc_clr, wc_inc, win_open;
	always_comb begin
		emit_en   = 1'b0;
		emit_byte = c;
		drop      = '0;
		wc_clr    = 1'b0;
		wc_inc    = 1'b0;
		win_open  = 1'b0;
		if (cmd.rejct) begin
			emit_en   = 1'b1;
			emit_byte = xed_pkg::CH_AMP;
			drop      = CW'(1);
			wc_clr    = 1'b1;
		end else if (cmd.emit) begin
			emit_en   = 1'b1;
			emit_byte = utf_byte;
		end else if (cmd.feed && wc_q == '0) begin
			if (c == xed_pkg::CH_AMP) begin
				win_open = 1'b1;
			end else begin
				emit_en = 1'b1;
				drop    = CW'(1);
			end
		end else if (feed_win) begin
			if (sts.decode_ok) begin
				drop   = wc_q + CW'(1);
				wc_clr = 1'b1;
			end else if (is_semi || full_next) begin
				emit_en   = 1'b1;
				emit_byte = xed_pkg::CH_AMP;
				drop      = CW'(1);
				wc_clr    = 1'b1;
			end else begin
				wc_inc = 1'b1;
			end
		end
	end

	// buffer write
	always_ff @(posedge clk) begin
		if (cmd.load)
			buf_q[wr_idx] <= text_byte;
	end

	// buffer pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			len_q  <= '0;
			wc_q   <= '0;
			seg_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				len_q <= len_q + CW'(1);
				seg_q <= segment_end;
			end else begin
				len_q <= len_q - drop;
			end
			head_q <= wrap_add(head_q, drop);
			if (wc_clr)
				wc_q <= '0;
			else if (win_open || wc_inc)
				wc_q <= wc_q + CW'(1);
		end
	end

	// incremental parse of the entity name
	logic [4:0] dg10, dg16, dgb;
	assign dg10 = xed_pkg::digit_val(c, 1'b0);
	assign dg16 = xed_pkg::digit_val(c, hex_q);
	assign dgb  = xed_pkg::digit_val(c, 1'b1);

	always_ff @(posedge clk) begin
		if (win_open) begin
			alive_q <= '0;
			hash_q  <= 1'b0;
			hex_q   <= 1'b0;
			acca_q  <= '0;
			accb_q  <= '0;
			runa_q  <= 1'b1;
			runb_q  <= 1'b0;
			pfx0_q  <= 1'b0;
			pfx_q   <= 1'b0;
			skip_q  <= 1'b0;
		end else if (wc_inc) begin
			if (ei == '0) begin
				hash_q <= (c == xed_pkg::CH_HASH);
				for (int k = 0; k < xed_pkg::NUM_NAMES; k++)
					alive_q[k] <= (c == 8'(xed_pkg::name_word(3'(k)) >> 24));
			end else begin
				for (int k = 0; k < xed_pkg::NUM_NAMES; k++) begin
					if (ei >= CW'(xed_pkg::name_len(3'(k))) || ei >= CW'(4))
						alive_q[k] <= 1'b0;
					else if (c != 8'(xed_pkg::name_word(3'(k)) >> (24 - 8 * int'(ei[1:0]))))
						alive_q[k] <= 1'b0;
				end
				if (ei == CW'(1) && (c == xed_pkg::CH_LOW_X || c == xed_pkg::CH_UP_X)) begin
					hex_q <= 1'b1;
				end else if (runa_q) begin
					if (ei == CW'(1) ? dg10[4] : dg16[4])
						acca_q <= hex_q ? ((acca_q << 4) + 32'(dg16[3:0]))
							: ((acca_q << 3) + (acca_q << 1) + 32'(dg10[3:0]));
					else
						runa_q <= 1'b0;
				end
				// "0x" prefix inside the hex digit run
				if (ei == CW'(2))
					pfx0_q <= (c == xed_pkg::CH_ZERO);
				if (ei == CW'(3))
					pfx_q <= pfx0_q && (c == xed_pkg::CH_LOW_X || c == xed_pkg::CH_UP_X);
				if (ei == CW'(4)) begin
					skip_q <= pfx_q && dgb[4];
					runb_q <= pfx_q && dgb[4];
					accb_q <= 32'(dgb[3:0]);
				end else if (ei > CW'(4) && runb_q) begin
					if (dgb[4])
						accb_q <= (accb_q << 4) + 32'(dgb[3:0]);
					else
						runb_q <= 1'b0;
				end
			end
		end
	end

	// encoder load
	always_ff @(posedge clk) begin
		if (feed_win && sts.decode_ok) begin
			if (name_hit) begin
				cp_q  <= 32'(name_chr);
				n_q   <= 3'd1;
				rem_q <= 3'd1;
			end else begin
				cp_q <= num_val;
				if (num_val < xed_pkg::UTF_LIM1) begin
					n_q <= 3'd1; rem_q <= 3'd1;
				end else if (num_val < xed_pkg::UTF_LIM2) begin
					n_q <= 3'd2; rem_q <= 3'd2;
				end else if (num_val < xed_pkg::UTF_LIM3) begin
					n_q <= 3'd3; rem_q <= 3'd3;
				end else begin
					n_q <= 3'd4; rem_q <= 3'd4;
				end
			end
		end else if (cmd.emit) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	// hold and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (emit_en) begin
				hold_valid_q <= 1'b1;
				if (hold_valid_q)
					res_valid_q <= 1'b1;
				else if (!res_stall)
					res_valid_q <= 1'b0;
			end else if (cmd.flush) begin
				hold_valid_q <= 1'b0;
				res_valid_q  <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			hold_q <= emit_byte;
			if (hold_valid_q) begin
				res_byte_q <= hold_q;
				res_seg_q  <= 1'b0;
				res_end_q  <= 1'b0;
			end
		end else if (cmd.flush) begin
			res_byte_q <= hold_q;
			res_seg_q  <= seg_q;
			res_end_q  <= 1'b1;
		end
	end

	assign res_valid       = res_valid_q;
	assign out_byte        = res_byte_q;
	assign out_segment_end = res_seg_q;
	assign run_end         = res_end_q;

endmodule

// ----- rtl/core/xml_entity_decoder_utf8_unit.sv -----
// ----------------------------------------------------------------------------
// xml_entity_decoder_utf8_unit
// Decodes XML character entities in a byte stream and emits UTF-8.
//
//   channel  dir  valid/stall             payload
//   text     in   text_valid/text_stall   text_byte, segment_end
//   res      out  res_valid/res_stall     out_byte, out_segment_end, run_end
//
// One request is processed at a time: the unit accepts it, steps each byte
// through the replay buffer (replays included), drops each candidate at
// segment end, emits each UTF-8 byte, sees the buffer drained and closes
// the run when it has results.
// Failed candidates replay up to ENTITY_REACH bytes from the buffer.
// Reset clears the buffer pointers and the output valid.
// A stalled result holds the unit once its hold register is also full.
// ----------------------------------------------------------------------------
module xml_entity_decoder_utf8_unit #(
	parameter int unsigned ENTITY_REACH = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	input  logic       segment_end,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_byte,
	output logic       out_segment_end,
	output logic       run_end
);

	xed_pkg::xed_cmd_t cmd;
	xed_pkg::xed_sts_t sts;

	xed_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	xed_dp #(
		.ENTITY_REACH (ENTITY_REACH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.text_byte       (text_byte),
		.segment_end     (segment_end),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.out_byte        (out_byte),
		.out_segment_end (out_segment_end),
		.run_end         (run_end),
		.cmd             (cmd),
		.sts             (sts)
	);

endmodule
